@@ design/ukfr_pkg.sv @@
package ukfr_pkg;

	localparam int UKFR_DEPTH = 16;

	localparam int KEY_W     = 64;
	localparam int HANDLER_W = 16;
	localparam int ENTRY_W   = KEY_W + HANDLER_W;

	// Request kinds.
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_POP    = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;

	// Result status codes.
	localparam logic [2:0] STAT_OK    = 3'd0;
	localparam logic [2:0] STAT_DUP   = 3'd1;
	localparam logic [2:0] STAT_FULL  = 3'd2;
	localparam logic [2:0] STAT_EMPTY = 3'd3;
	localparam logic [2:0] STAT_MISS  = 3'd4;

	typedef struct packed {
		logic [1:0]           kind;
		logic [KEY_W-1:0]     key;
		logic [HANDLER_W-1:0] handler_ref;
	} req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [KEY_W-1:0]     out_key;
		logic [HANDLER_W-1:0] out_handler;
		logic [4:0]           entry_count;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_POP
	} ukfr_state_t;

endpackage

@@ design/ukfr_ram.sv @@
module ukfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port, single registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/unique_key_fifo_registry.sv @@
// A pop on a non-empty store loads its result in S_POP, the state after acceptance; a pop on an
// empty store and an unused kind load it at acceptance; insert and lookup load it when the scan
// ends, so their wait grows with the number of stored entries. done is the registered load.
// One transaction at a time, the next accepted only once busy is low;
// insert and lookup compare one stored key per cycle through the single memory read port.
// Asynchronous active-low reset empties the registry at once; memory needs no clearing pass.
module unique_key_fifo_registry #(
	parameter int DEPTH = ukfr_pkg::UKFR_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ukfr_pkg::req_t req,
	output logic           done,
	output ukfr_pkg::rsp_t rsp
);

	import ukfr_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Control state.
	ukfr_state_t state_q, state_d;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] addr_q;
	logic [CW-1:0] issued_q;
	logic          rvalid_s1;
	logic          done_q;

	// The captured request and the result register.
	req_t req_q;
	rsp_t rsp_q;

	// Entry memory interface.
	logic               ram_we;
	logic [AW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [KEY_W-1:0]     rd_key;
	logic [HANDLER_W-1:0] rd_handler;

	// Decoded controls from the output block.
	logic          accept;
	logic          issue;
	logic          hit;
	logic          scan_end;
	logic          rsp_load;
	rsp_t          rsp_d;
	logic          head_adv;
	logic          tail_adv;
	logic [CW-1:0] count_d;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
		return (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
	endfunction

	// Key and handler live side by side in one memory word.
	ukfr_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata({req_q.key, req_q.handler_ref}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_key     = ram_rdata[ENTRY_W-1:HANDLER_W];
	assign rd_handler = ram_rdata[HANDLER_W-1:0];

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign rsp    = rsp_q;

	// While idle the read port looks at the oldest slot so that a pop finds its entry waiting
	// in the next cycle. During a scan it walks from the oldest entry toward the newest.
	assign ram_raddr = (state_q == S_SCAN) ? addr_q : head_q;

	// A comparison is valid in the cycle after its read was issued. The scan stops at the first
	// match, or once every live entry has been read and compared.
	assign hit      = (state_q == S_SCAN) && rvalid_s1 && (rd_key == req_q.key);
	assign scan_end = hit || (issued_q == count_q);
	assign issue    = (state_q == S_SCAN) && !hit && (issued_q < count_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.kind) inside
						KIND_INSERT, KIND_LOOKUP: state_d = S_SCAN;
						KIND_POP:                 state_d = (count_q != '0) ? S_POP : S_IDLE;
						default:                  state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					state_d = S_IDLE;
				end
			end
			S_POP: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the controller: the result, the memory write and the pointer updates.
	always_comb begin
		rsp_load = 1'b0;
		ram_we   = 1'b0;
		head_adv = 1'b0;
		tail_adv = 1'b0;
		count_d  = count_q;
		rsp_d    = '0;
		rsp_d.status = STAT_OK;
		unique case (state_q)
			S_IDLE: begin
				// A pop on an empty store and the unused kind finish without touching memory.
				if (accept) begin
					unique case (req.kind) inside
						KIND_POP: begin
							if (count_q == '0) begin
								rsp_load     = 1'b1;
								rsp_d.status = STAT_EMPTY;
							end
						end
						KIND_INSERT, KIND_LOOKUP: begin
							rsp_load = 1'b0;
						end
						default: begin
							rsp_load = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				rsp_load          = 1'b1;
				rsp_d.out_key     = rd_key;
				rsp_d.out_handler = rd_handler;
				head_adv          = 1'b1;
				count_d           = count_q - CW'(1);
			end
			S_SCAN: begin
				if (scan_end) begin
					rsp_load = 1'b1;
					if (req_q.kind == KIND_INSERT) begin
						// The duplicate check takes precedence over the full check.
						if (hit) begin
							rsp_d.status = STAT_DUP;
						end else if (count_q == CW'(DEPTH)) begin
							rsp_d.status = STAT_FULL;
						end else begin
							ram_we   = 1'b1;
							tail_adv = 1'b1;
							count_d  = count_q + CW'(1);
						end
					end else begin
						if (hit) begin
							rsp_d.out_key     = rd_key;
							rsp_d.out_handler = rd_handler;
						end else begin
							rsp_d.status = STAT_MISS;
						end
					end
				end
			end
			default: begin
				rsp_load = 1'b0;
			end
		endcase
		// The reported count is the low bits of the count after this transaction.
		rsp_d.entry_count = 5'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			addr_q    <= '0;
			issued_q  <= '0;
			rvalid_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			done_q    <= rsp_load;
			rvalid_s1 <= issue;
			if (head_adv) begin
				head_q <= next_slot(head_q);
			end
			if (tail_adv) begin
				tail_q <= next_slot(tail_q);
			end
			if (accept) begin
				addr_q   <= head_q;
				issued_q <= '0;
			end else if (issue) begin
				addr_q   <= next_slot(addr_q);
				issued_q <= issued_q + CW'(1);
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

`ifndef SYNTH
	// The live count never exceeds the capacity of the store.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	// A scan never reads more entries than are live.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (issued_q <= count_q))
		else $error("scan ran past the live entries");

	// An insert commits only when a free slot exists.
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (count_q < CW'(DEPTH)))
		else $error("write into a full store");

	// A pop reaches its data cycle only with an entry to remove.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> (count_q != '0))
		else $error("pop of an empty store");

	// Each result strobe follows an acceptance or a busy cycle.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> ($past(start && !busy) || $past(state_q != S_IDLE)))
		else $error("result strobe without a transaction");
`endif

endmodule

@@ bench/tb_unique_key_fifo_registry.sv @@
module tb_unique_key_fifo_registry;
	timeunit 1ns;
	timeprecision 1ps;

	import ukfr_pkg::*;

	// The package names the three real request kinds only. The fourth encoding is legal
	// on the wire and must leave the registry untouched.
	localparam logic [1:0] KIND_SPARE = 2'd3;

	localparam int unsigned RUN_LIMIT = 400000;
	localparam int unsigned POOL_SIZE = 24;
	localparam int unsigned RANDOM_ITEMS = 1524;
	localparam int unsigned QUIET_TAIL = 200;

	// One queued transaction for the driver: the request itself, the number of idle
	// cycles to leave before offering it, and whether to hold it back until every
	// outstanding result has come back.
	typedef struct {
		req_t        body;
		int unsigned gap;
		bit          drain;
	} queued_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	queued_req_t request_backlog[$];
	rsp_t        awaited_responses[$];

	int unsigned mismatch_count = 0;
	int unsigned accepted_count = 0;
	int unsigned total_items = 0;
	int unsigned cycle_count = 0;

	// Shadow copy of the registry: a circular store with head, tail and live count.
	logic [KEY_W-1:0]     shadow_keys[UKFR_DEPTH];
	logic [HANDLER_W-1:0] shadow_handlers[UKFR_DEPTH];
	int unsigned          shadow_head = 0;
	int unsigned          shadow_tail = 0;
	int unsigned          shadow_count = 0;

	// Driver scratch state.
	bit          line_free;
	bit          launch_now;
	bit          gap_loaded = 1'b0;
	int unsigned gap_left = 0;
	queued_req_t next_item;
	rsp_t        want_rsp;

	unique_key_fifo_registry DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Applies one accepted request to the shadow registry and queues the response the
	// block must give for it. The key search only walks live entries, oldest first, so
	// a slot that was never written is never compared.
	function automatic void apply_request(input req_t r);
		rsp_t        resp;
		bit          hit;
		int unsigned hit_slot;
		int unsigned s;
		resp = '0;
		resp.status = STAT_OK;
		hit = 1'b0;
		hit_slot = 0;
		s = shadow_head;
		for (int unsigned i = 0; i < shadow_count; i++) begin
			if (!hit && shadow_keys[s] == r.key) begin
				hit = 1'b1;
				hit_slot = s;
			end
			s = (s + 1) % UKFR_DEPTH;
		end
		case (r.kind)
			KIND_INSERT: begin
				// A duplicate key is reported even when the store is also full.
				if (hit) begin
					resp.status = STAT_DUP;
				end else if (shadow_count >= UKFR_DEPTH) begin
					resp.status = STAT_FULL;
				end else begin
					shadow_keys[shadow_tail] = r.key;
					shadow_handlers[shadow_tail] = r.handler_ref;
					shadow_tail = (shadow_tail + 1) % UKFR_DEPTH;
					shadow_count++;
				end
			end
			KIND_POP: begin
				if (shadow_count == 0) begin
					resp.status = STAT_EMPTY;
				end else begin
					resp.out_key = shadow_keys[shadow_head];
					resp.out_handler = shadow_handlers[shadow_head];
					shadow_head = (shadow_head + 1) % UKFR_DEPTH;
					shadow_count--;
				end
			end
			KIND_LOOKUP: begin
				if (hit) begin
					resp.out_key = shadow_keys[hit_slot];
					resp.out_handler = shadow_handlers[hit_slot];
				end else begin
					resp.status = STAT_MISS;
				end
			end
			default: begin
				// The spare kind reports OK with zero payload and changes nothing.
			end
		endcase
		resp.entry_count = shadow_count[4:0];
		awaited_responses.push_back(resp);
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] seen,
			input logic [63:0] wanted);
		$display("MISMATCH at %0t: %s is %h, expected %h", $realtime, what, seen, wanted);
		mismatch_count++;
	endtask

	task automatic queue_request(input logic [1:0] kind, input logic [KEY_W-1:0] key,
			input logic [HANDLER_W-1:0] handler, input int unsigned gap, input bit drain);
		queued_req_t item;
		item.body.kind = kind;
		item.body.key = key;
		item.body.handler_ref = handler;
		item.gap = gap;
		item.drain = drain;
		request_backlog.push_back(item);
	endtask

	// Driver. A transaction is accepted at an edge where start is high and busy is low;
	// that is the moment the shadow registry is updated. Whenever the request line is
	// free (nothing offered, or the offer was just taken) the next queued request is
	// considered: first its idle gap runs out, then a drain request waits until no
	// response is outstanding, and only then is it put on the port. start and req get
	// at most one nonblocking assignment per edge, so back-to-back offers keep start high.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			line_free = !start || !busy;
			if (start && !busy) begin
				apply_request(req);
				accepted_count++;
			end
			if (line_free) begin
				launch_now = 1'b0;
				if (request_backlog.size() != 0) begin
					if (!gap_loaded) begin
						gap_left = request_backlog[0].gap;
						gap_loaded = 1'b1;
					end
					if (gap_left > 0) begin
						gap_left--;
					end else if (!(request_backlog[0].drain && awaited_responses.size() != 0)) begin
						next_item = request_backlog.pop_front();
						gap_loaded = 1'b0;
						launch_now = 1'b1;
					end
				end
				start <= launch_now;
				if (launch_now) begin
					req <= next_item.body;
				end
			end
		end
	end

	// Monitor. The done strobe lasts one cycle and cannot be held off, so every edge with
	// done high carries exactly one response. It is matched against the oldest one awaited.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (awaited_responses.size() == 0) begin
				flag_mismatch("unrequested response, status", 64'(rsp.status), '0);
			end else begin
				want_rsp = awaited_responses.pop_front();
				if (rsp.status !== want_rsp.status) begin
					flag_mismatch("status", 64'(rsp.status), 64'(want_rsp.status));
				end
				if (rsp.out_key !== want_rsp.out_key) begin
					flag_mismatch("out_key", rsp.out_key, want_rsp.out_key);
				end
				if (rsp.out_handler !== want_rsp.out_handler) begin
					flag_mismatch("out_handler", 64'(rsp.out_handler),
						64'(want_rsp.out_handler));
				end
				if (rsp.entry_count !== want_rsp.entry_count) begin
					flag_mismatch("entry_count", 64'(rsp.entry_count),
						64'(want_rsp.entry_count));
				end
			end
		end
	end

	// Watchdog: the slowest legal run is far below this many cycles.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [KEY_W-1:0]     key_pool[POOL_SIZE];
		logic [KEY_W-1:0]     fill_key;
		logic [KEY_W-1:0]     pick_key;
		logic [1:0]           pick_kind;
		int unsigned          insert_weight;
		int unsigned          roll;
		int unsigned          gap;
		bit                   idle_on;

		// A small key pool makes duplicates, lookup hits and a full store common. The
		// two extreme keys are always part of it.
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int unsigned i = 2; i < POOL_SIZE; i++) begin
			key_pool[i] = {$urandom, $urandom};
		end

		// Directed part. The store starts empty: pop and lookup on an empty store, the
		// spare kind, the extreme keys and handlers, a duplicate insert, then filling to
		// DEPTH so that a new key is refused as full while a stored one is still refused
		// as a duplicate. A lookup of the newest entry scans the whole store.
		queue_request(KIND_POP, '1, '1, 0, 1'b0);
		queue_request(KIND_LOOKUP, '0, '0, 0, 1'b0);
		queue_request(KIND_SPARE, '1, '1, 2, 1'b0);
		queue_request(KIND_INSERT, '0, '0, 0, 1'b0);
		queue_request(KIND_INSERT, '1, '1, 0, 1'b0);
		queue_request(KIND_INSERT, '0, 16'h1234, 1, 1'b0);
		queue_request(KIND_LOOKUP, '1, '0, 0, 1'b0);
		fill_key = '0;
		for (int unsigned i = 2; i < UKFR_DEPTH; i++) begin
			fill_key = key_pool[i];
			queue_request(KIND_INSERT, fill_key, 16'($urandom_range(0, 65535)), 0, 1'b0);
		end
		queue_request(KIND_INSERT, key_pool[UKFR_DEPTH], 16'hA5A5, 0, 1'b0);
		queue_request(KIND_INSERT, '0, 16'h5A5A, 0, 1'b0);
		queue_request(KIND_LOOKUP, fill_key, '1, 0, 1'b0);
		queue_request(KIND_LOOKUP, 64'h5555_5555_5555_5555, '1, 3, 1'b0);
		queue_request(KIND_POP, '0, '0, 0, 1'b0);

		// Random part, in blocks of 40 with their own insert bias so that the store
		// swings between empty and full and the indexes wrap many times. Some blocks
		// idle the sender in short bursts; the tail of the run is sent back to back.
		insert_weight = 50;
		idle_on = 1'b0;
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: insert_weight = 25;
					1: insert_weight = 50;
					default: insert_weight = 75;
				endcase
				idle_on = 1'($urandom_range(0, 1));
			end
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				pick_kind = KIND_SPARE;
			end else if (roll < 4 + insert_weight) begin
				pick_kind = KIND_INSERT;
			end else if (roll < 4 + insert_weight + (96 - insert_weight) / 2) begin
				pick_kind = KIND_POP;
			end else begin
				pick_kind = KIND_LOOKUP;
			end
			if ($urandom_range(0, 99) < 85) begin
				pick_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			end else begin
				pick_key = {$urandom, $urandom};
			end
			gap = 0;
			if (idle_on && n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 5);
			end
			// The first random transaction and one in the middle wait for a fully
			// drained block before they go out.
			queue_request(pick_kind, pick_key, 16'($urandom_range(0, 65535)), gap,
				n == 0 || n == RANDOM_ITEMS / 2);
		end
		total_items = request_backlog.size();

		while (accepted_count < total_items) begin
			@(posedge clk);
		end
		while (awaited_responses.size() != 0) begin
			@(posedge clk);
		end
		// Waiting on after that catches any stray strobe after the last expected response.
		repeat (UKFR_DEPTH + 4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
